// ===== rtl/swpq_pkg.sv =====
// Shared types and constants for the stable weighted priority queue.
// No dependencies; every other file of the block imports this package.
package swpq_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned GradeW   = 12;
  localparam int unsigned CoursesW = 8;
  localparam int unsigned KeyW     = 21;
  localparam int unsigned RegW     = 8;
  localparam int unsigned CountW   = 5;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OpW      = 2;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [RegW-1:0] GradeCapRst   = 8'd10;
  localparam logic [RegW-1:0] CourseGoalRst = 8'd40;

  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_OUT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_APPLY,
    S_REPORT
  } state_e;

  // Register index as decoded from paddr[2]
  typedef enum logic {
    REG_GRADE_CAP   = 1'b0,
    REG_COURSE_GOAL = 1'b1
  } reg_e;

  typedef struct packed {
    logic [ValueW-1:0]   value;
    logic [GradeW-1:0]   grade;
    logic [CoursesW-1:0] courses;
    logic [KeyW-1:0]     key;
  } entry_t;

  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [KeyW-1:0] key;
  } cell_cmd_t;

endpackage

// ===== rtl/stable_weighted_priority_queue.sv =====
// Top level of the stable weighted priority queue: APB registers,
// sequencer, key unit and the chain of swpq_cell slots. Depends on swpq_pkg.
//
//  port group  dir  fields (low bit up)
//  s_axis      in   tuser: op[1:0]; tdata: item_value, grade, courses
//  m_axis      out  tdata: front_value, front_grade, front_courses, front_key,
//                   count, is_empty, status
//  apb         in   grade cap @0x0, course goal @0x4
//
// An item passes through four steps: accept, key compute, chain update, result load.
// The next beat is accepted once the result sits in the output register.
// The four-step sequencer paces the items; the chain updates all slots at once.
// Reset empties the queue and loads grade cap 10, course goal 40.
// A stalled result holds in the output register; one more item may enter and
// waits in the result-load step.
module stable_weighted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [swpq_pkg::InDataW-1:0]     s_axis_tdata,   // item_value, grade, courses
  input  logic [swpq_pkg::OpW-1:0]         s_axis_tuser,   // op
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // front_value, front_grade, front_courses, front_key, count, is_empty, status
  output logic [swpq_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [swpq_pkg::ApbAddrW-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import swpq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // configuration registers
  logic [RegW-1:0] grade_cap_q, course_goal_q;
  logic            cfg_wr;
  reg_e            cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grade_cap_q   <= GradeCapRst;
      course_goal_q <= CourseGoalRst;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GRADE_CAP:   grade_cap_q   <= pwdata[RegW-1:0];
        REG_COURSE_GOAL: course_goal_q <= pwdata[RegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GRADE_CAP:   prdata = 32'(grade_cap_q);
      REG_COURSE_GOAL: prdata = 32'(course_goal_q);
      default:         prdata = '0;
    endcase
  end

  // sequencer
  state_e state_q, state_d;
  logic   in_beat, out_free;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (s_axis_tvalid) state_d = S_CALC;
      S_CALC:   state_d = S_APPLY;
      S_APPLY:  state_d = S_REPORT;
      S_REPORT: if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // captured item
  op_e                 op_q;
  logic [ValueW-1:0]   value_q;
  logic [GradeW-1:0]   grade_q;
  logic [CoursesW-1:0] courses_q;

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q      <= op_e'(s_axis_tuser);
      value_q   <= s_axis_tdata[ValueW-1:0];
      grade_q   <= s_axis_tdata[ValueW +: GradeW];
      courses_q <= s_axis_tdata[ValueW+GradeW +: CoursesW];
    end
  end

  // key and decision
  logic [KeyW-1:0] key_w;
  logic            range_bad;

  swpq_key u_key (
    .grade_i       (grade_q),
    .courses_i     (courses_q),
    .grade_cap_i   (grade_cap_q),
    .course_goal_i (course_goal_q),
    .key_o         (key_w),
    .range_bad_o   (range_bad)
  );

  logic [CntW-1:0] count_q;
  logic            full, empty;
  logic [KeyW-1:0] key_q;
  status_e         stat_q, stat_d;
  logic            ins_q, rem_q, clr_q;
  logic            ins_d, rem_d, clr_d;

  assign full  = (count_q == CntW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    ins_d  = 1'b0;
    rem_d  = 1'b0;
    clr_d  = 1'b0;
    stat_d = ST_OK;
    if (state_q == S_CALC) begin
      unique case (op_q)
        OP_INSERT: begin
          priority if (range_bad) stat_d = ST_OUT_RANGE;
          else if (full)          stat_d = ST_FULL;
          else                    ins_d  = 1'b1;
        end
        OP_REMOVE: begin
          if (empty) stat_d = ST_EMPTY;
          else       rem_d  = 1'b1;
        end
        OP_CLEAR: clr_d = 1'b1;
        OP_NONE:  ;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q  <= 1'b0;
      rem_q  <= 1'b0;
      clr_q  <= 1'b0;
      stat_q <= ST_OK;
    end else if (state_q == S_CALC) begin
      ins_q  <= ins_d;
      rem_q  <= rem_d;
      clr_q  <= clr_d;
      stat_q <= stat_d;
    end else if (state_q == S_APPLY) begin
      ins_q <= 1'b0;
      rem_q <= 1'b0;
      clr_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC) key_q <= key_w;
  end

  // entry count
  logic            apply;
  logic [CntW-1:0] count_d;

  assign apply = (state_q == S_APPLY);

  always_comb begin
    count_d = count_q;
    if (apply) begin
      priority if (clr_q) count_d = '0;
      else if (ins_q)     count_d = count_q + CntW'(1);
      else if (rem_q)     count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= '0;
    else         count_q <= count_d;
  end

  // chain of cells
  cell_cmd_t cmd;
  entry_t    new_entry;
  entry_t    entry_w [DEPTH];
  logic      ge_w    [DEPTH];
  logic      occ     [DEPTH];

  assign cmd.ins = apply && ins_q;
  assign cmd.rem = apply && rem_q;
  assign cmd.key = key_q;

  assign new_entry.value   = value_q;
  assign new_entry.grade   = grade_q;
  assign new_entry.courses = courses_q;
  assign new_entry.key     = key_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left, right;
    logic   left_ge;

    assign occ[i] = (count_q > CntW'(i));

    if (i == 0) begin : g_head
      assign left    = new_entry;
      assign left_ge = 1'b1;
    end else begin : g_body
      assign left    = entry_w[i-1];
      assign left_ge = ge_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right = entry_w[i];
    end else begin : g_next
      assign right = entry_w[i+1];
    end

    swpq_cell u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .occ_i     (occ[i]),
      .new_i     (new_entry),
      .left_i    (left),
      .left_ge_i (left_ge),
      .right_i   (right),
      .entry_o   (entry_w[i]),
      .ge_o      (ge_w[i])
    );
  end

  // result register
  entry_t front;
  logic   load_out;

  assign front    = occ[0] ? entry_w[0] : '0;
  assign load_out = (state_q == S_REPORT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_axis_tdata <= {7'h0, stat_q, empty, CountW'(count_q), front.key,
                       front.courses, front.grade, front.value};
    end
  end

endmodule

// ===== rtl/swpq_key.sv =====
// Priority key and range check for one insert.
// Depends on swpq_pkg.
module swpq_key (
  input  logic [swpq_pkg::GradeW-1:0]   grade_i,
  input  logic [swpq_pkg::CoursesW-1:0] courses_i,
  input  logic [swpq_pkg::RegW-1:0]     grade_cap_i,
  input  logic [swpq_pkg::RegW-1:0]     course_goal_i,
  output logic [swpq_pkg::KeyW-1:0]     key_o,
  output logic                          range_bad_o
);
  import swpq_pkg::*;

  logic [GradeW+RegW-1:0]   prod_g;
  logic [CoursesW+RegW-1:0] prod_c;

  always_comb begin
    prod_g = (GradeW+RegW)'(grade_i) * (GradeW+RegW)'(course_goal_i);
    prod_c = (CoursesW+RegW)'(courses_i) * (CoursesW+RegW)'(grade_cap_i);
    // course term carries the x16 of the 8.4 grade scale
    key_o  = KeyW'(prod_g) + KeyW'({prod_c, 4'h0});
    range_bad_o = (grade_i > {grade_cap_i, 4'h0}) || (courses_i > course_goal_i);
  end

endmodule

// ===== rtl/swpq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares against the
// insert key and shifts with its neighbors. Depends on swpq_pkg.
module swpq_cell (
  input  logic                clk_i,
  input  swpq_pkg::cell_cmd_t cmd_i,
  input  logic                occ_i,
  input  swpq_pkg::entry_t    new_i,
  input  swpq_pkg::entry_t    left_i,
  input  logic                left_ge_i,
  input  swpq_pkg::entry_t    right_i,
  output swpq_pkg::entry_t    entry_o,
  output logic                ge_o
);
  import swpq_pkg::*;

  entry_t entry_q, entry_d;

  assign ge_o    = occ_i && (entry_q.key >= cmd_i.key);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins && !ge_o) begin
      // first slot below the key takes the new entry, the rest shift down
      entry_d = left_ge_i ? new_i : left_i;
    end else if (cmd_i.rem) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== rtl/swpq_checker.sv =====
// Port-level checks for stable_weighted_priority_queue, bound to the top.
// Depends on swpq_pkg.
module swpq_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [swpq_pkg::OutDataW-1:0] m_axis_tdata
);
  import swpq_pkg::*;

  logic                is_empty;
  logic [CountW-1:0]   cnt;
  logic [StatusW-1:0]  stat;

  assign cnt      = m_axis_tdata[77:73];
  assign is_empty = m_axis_tdata[78];
  assign stat     = m_axis_tdata[80:79];

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (is_empty == (cnt == '0)))
    else $error("is_empty disagrees with count");

  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && is_empty |-> (m_axis_tdata[72:0] == '0))
    else $error("front fields not zero on empty queue");

  a_remove_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (stat == ST_EMPTY) |-> is_empty)
    else $error("remove-on-empty status with entries held");

  // a new beat cannot be taken in the cycle right after one was taken
  a_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

endmodule

bind stable_weighted_priority_queue swpq_checker u_swpq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
